/* sv/trlr_pkg.sv */
package trlr_pkg;

    // Sizing of the block.
    localparam int MAX_MOTIFS   = 8;
    localparam int RUN_BITS     = 16;
    localparam int BASE_LIMIT   = 4;
    localparam int MOTIF_BITS   = 3;
    localparam int LONGEST_BITS = 16;
    localparam int MOTIF_WIDTH  = 8;
    localparam int TABLE_BITS   = 64;
    localparam int COUNT_BITS   = 4;

    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
    localparam logic [8:0]          RECENT_INVALID = 9'h1FF;

    // Configuration register indexes.
    localparam logic CFG_MOTIF_TABLE = 1'b0;
    localparam logic CFG_MOTIF_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0] base;
        logic       final_base;
    } item_t;

    typedef struct packed {
        logic [MOTIF_BITS-1:0]   motif_index;
        logic [LONGEST_BITS-1:0] longest_run;
        logic                    report_end;
    } report_t;

    // Snapshot handed from the run core to the report stage on a final base.
    typedef struct packed {
        logic                                      valid;
        logic [MOTIF_BITS-1:0]                     last;
        logic [MAX_MOTIFS-1:0][LONGEST_BITS-1:0]   rows;
    } rpt_load_t;

    // Index of the last motif in use: a count of zero means one motif, and
    // a count above the table size is held at the table size.
    function automatic logic [MOTIF_BITS-1:0] active_last(input logic [COUNT_BITS-1:0] count);
        logic [COUNT_BITS-1:0] t;
        begin
            t = count - 4'd1;
            if (count == 4'd0)
            begin
                return '0;
            end
            else if (count > COUNT_BITS'(MAX_MOTIFS))
            begin
                return MOTIF_BITS'(MAX_MOTIFS - 1);
            end
            else
            begin
                return t[MOTIF_BITS-1:0];
            end
        end
    endfunction

    // Clamp a run count to the width of the report field.
    function automatic logic [LONGEST_BITS-1:0] clamp_run(input logic [RUN_BITS-1:0] v);
        logic [RUN_BITS+LONGEST_BITS-1:0] wide;
        begin
            wide = (RUN_BITS + LONGEST_BITS)'(v);
            if (wide > (RUN_BITS + LONGEST_BITS)'({LONGEST_BITS{1'b1}}))
            begin
                return '1;
            end
            else
            begin
                return wide[LONGEST_BITS-1:0];
            end
        end
    endfunction

endpackage

/* sv/trlr_run_core.sv */
module trlr_run_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  trlr_pkg::item_t                       item,
    input  logic [trlr_pkg::TABLE_BITS-1:0]       motif_table,
    input  logic [trlr_pkg::MOTIF_BITS-1:0]       last_motif,
    output trlr_pkg::rpt_load_t                   load
);

    logic [8:0] recent_reg, recent_next;
    logic [1:0] fill_reg, fill_next;
    logic [1:0] phase_reg, phase_next;
    logic [trlr_pkg::RUN_BITS-1:0] run_reg  [trlr_pkg::MAX_MOTIFS][4];
    logic [trlr_pkg::RUN_BITS-1:0] run_next [trlr_pkg::MAX_MOTIFS][4];
    logic [trlr_pkg::RUN_BITS-1:0] best_reg  [trlr_pkg::MAX_MOTIFS];
    logic [trlr_pkg::RUN_BITS-1:0] best_next [trlr_pkg::MAX_MOTIFS];
    logic [7:0] window;

    // Oldest base sits in the low bits of the window, as in the motif byte.
    assign window = {item.base[1:0], recent_reg[1:0], recent_reg[4:3], recent_reg[7:6]};

    always_comb
    begin
        logic [trlr_pkg::RUN_BITS-1:0] inc_run;
        inc_run     = '0;
        recent_next = recent_reg;
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        run_next    = run_reg;
        best_next   = best_reg;
        load.valid  = 1'b0;
        load.last   = last_motif;
        if (accept)
        begin
            if (item.base >= 3'(trlr_pkg::BASE_LIMIT))
            begin
                for (int m = 0; m < trlr_pkg::MAX_MOTIFS; m++)
                begin
                    for (int p = 0; p < 4; p++)
                    begin
                        run_next[m][p] = '0;
                    end
                end
                recent_next = trlr_pkg::RECENT_INVALID;
                fill_next   = 2'd0;
            end
            else
            begin
                if (fill_reg == 2'd3)
                begin
                    for (int m = 0; m < trlr_pkg::MAX_MOTIFS; m++)
                    begin
                        if (3'(m) <= last_motif)
                        begin
                            if (motif_table[m*trlr_pkg::MOTIF_WIDTH +: trlr_pkg::MOTIF_WIDTH]
                                == window)
                            begin
                                inc_run = (run_reg[m][phase_reg] == trlr_pkg::RUN_MAX)
                                          ? trlr_pkg::RUN_MAX
                                          : run_reg[m][phase_reg] + 1'b1;
                                run_next[m][phase_reg] = inc_run;
                                if (inc_run > best_reg[m])
                                begin
                                    best_next[m] = inc_run;
                                end
                            end
                            else
                            begin
                                run_next[m][phase_reg] = '0;
                            end
                        end
                    end
                end
                recent_next = {recent_reg[5:0], item.base};
                if (fill_reg != 2'd3)
                begin
                    fill_next = fill_reg + 2'd1;
                end
            end
            phase_next = phase_reg + 2'd1;
        end
        for (int m = 0; m < trlr_pkg::MAX_MOTIFS; m++)
        begin
            load.rows[m] = trlr_pkg::clamp_run(best_next[m]);
        end
        // The final base is counted, reported, then the sequence state clears.
        if (accept && item.final_base)
        begin
            load.valid  = 1'b1;
            recent_next = trlr_pkg::RECENT_INVALID;
            fill_next   = 2'd0;
            phase_next  = 2'd0;
            for (int m = 0; m < trlr_pkg::MAX_MOTIFS; m++)
            begin
                best_next[m] = '0;
                for (int p = 0; p < 4; p++)
                begin
                    run_next[m][p] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= trlr_pkg::RECENT_INVALID;
            fill_reg   <= 2'd0;
            phase_reg  <= 2'd0;
            for (int m = 0; m < trlr_pkg::MAX_MOTIFS; m++)
            begin
                best_reg[m] <= '0;
                for (int p = 0; p < 4; p++)
                begin
                    run_reg[m][p] <= '0;
                end
            end
        end
        else
        begin
            recent_reg <= recent_next;
            fill_reg   <= fill_next;
            phase_reg  <= phase_next;
            best_reg   <= best_next;
            run_reg    <= run_next;
        end
    end

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.final_base) |=> (phase_reg == 2'd0 && fill_reg == 2'd0))
        else $error("sequence state not cleared after final base");

    a_break_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.base >= 3'(trlr_pkg::BASE_LIMIT))
        |=> (fill_reg == 2'd0 && recent_reg == trlr_pkg::RECENT_INVALID))
        else $error("non-ACGT symbol did not break the window");

    a_full_window: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd3) |-> (!recent_reg[8] && !recent_reg[5] && !recent_reg[2]))
        else $error("full window holds an invalid base");

endmodule

/* sv/trlr_report.sv */
module trlr_report (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trlr_pkg::rpt_load_t  load,
    output logic                 busy,
    output logic                 report_valid,
    input  logic                 report_stall,
    output trlr_pkg::report_t    report
);

    logic [trlr_pkg::LONGEST_BITS-1:0] rows_reg [trlr_pkg::MAX_MOTIFS];
    logic [trlr_pkg::MOTIF_BITS-1:0]   idx_reg;
    logic [trlr_pkg::MOTIF_BITS-1:0]   last_reg;
    logic                              busy_reg;
    logic                              take;

    assign take               = busy_reg && !report_stall;
    assign busy               = busy_reg;
    assign report_valid       = busy_reg;
    assign report.motif_index = idx_reg;
    assign report.longest_run = rows_reg[idx_reg];
    assign report.report_end  = (idx_reg == last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            last_reg <= '0;
        end
        else if (load.valid)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            last_reg <= load.last;
        end
        else if (take)
        begin
            if (idx_reg == last_reg)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            for (int m = 0; m < trlr_pkg::MAX_MOTIFS; m++)
            begin
                rows_reg[m] <= load.rows[m];
            end
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        load.valid |-> !busy_reg)
        else $error("report loaded while a report is still draining");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (idx_reg <= last_reg))
        else $error("report row beyond last motif");

    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (take && report.report_end && !load.valid) |=> !busy_reg)
        else $error("report kept running after its last row");

endmodule

/* sv/tandem_repeat_longest_run_unit.sv */
// Short tandem repeat counter: one DNA base word is taken per cycle on the item channel
// and checked, as the newest base of a four-base window, against up to eight four-base
// motifs from the motif_table register (motif_count says how many are in use). For each
// motif the block keeps a run count for each of the four alignments and the longest run
// so far; a symbol other than A, C, G or T breaks every run. When a word marked
// final_base is taken, the block reports one row per motif in use on the report channel,
// starting in the next cycle and giving one row per cycle while report_stall is low, with
// report_end on the last row; all counters clear at once, so the next sequence may start
// in the following cycle. The rate is one base per cycle, set by the single registered
// pass of the run core. The only hold-off comes from the report stage, which holds one
// report: a further final base is stalled until the previous report has drained.
// Configuration is written through the cfg channel, which is always ready; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module tandem_repeat_longest_run_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  trlr_pkg::item_t                       item,
    output logic                                  report_valid,
    input  logic                                  report_stall,
    output trlr_pkg::report_t                     report,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic                                  cfg_index,
    input  logic [trlr_pkg::TABLE_BITS-1:0]       cfg_data
);

    logic [trlr_pkg::TABLE_BITS-1:0] motif_table_reg;
    logic [trlr_pkg::COUNT_BITS-1:0] motif_count_reg;
    logic [trlr_pkg::MOTIF_BITS-1:0] last_motif;
    logic                            accept;
    logic                            rpt_busy;
    trlr_pkg::rpt_load_t             load;

    // Configuration writes always complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_table_reg <= '0;
            motif_count_reg <= 4'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                trlr_pkg::CFG_MOTIF_TABLE: motif_table_reg <= cfg_data;
                trlr_pkg::CFG_MOTIF_COUNT: motif_count_reg <= cfg_data[trlr_pkg::COUNT_BITS-1:0];
                default:                   motif_table_reg <= motif_table_reg;
            endcase
        end
    end

    assign last_motif = trlr_pkg::active_last(motif_count_reg);

    // Only a final base has to wait, and only while the previous report drains.
    assign item_stall = rpt_busy && item.final_base;
    assign accept     = item_valid && !item_stall;

    trlr_run_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .motif_table (motif_table_reg),
        .last_motif  (last_motif),
        .load        (load)
    );

    trlr_report u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .busy         (rpt_busy),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

    a_final_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.final_base) |=> (report_valid && report.motif_index == '0))
        else $error("final base did not start a report");

    a_stall_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (item.final_base && report_valid))
        else $error("input stalled without a pending report");

    a_last_row_index: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && report.report_end) |-> (report.motif_index == last_motif))
        else $error("report ended on the wrong motif");

endmodule
